// ===== rtl/ber_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// BER encoder package
// Widths, operation codes and the octet frame type shared by the encoder.
// ----------------------------------------------------------------------------
package ber_enc_pkg;

	localparam int OP_W       = 3;
	localparam int TAG_W      = 8;
	localparam int VALUE_W    = 32;
	localparam int OCTET_W    = 8;
	localparam int MAX_OCTETS = 7;
	localparam int CNT_W      = 3;

	// Operand bits that take part in the encoding; bit VALUE_BITS-1 is the sign.
	localparam int VALUE_BITS = 32;

	localparam logic [OP_W-1:0] OP_NULL   = 3'd0;
	localparam logic [OP_W-1:0] OP_BOOL   = 3'd1;
	localparam logic [OP_W-1:0] OP_SINT   = 3'd2;
	localparam logic [OP_W-1:0] OP_UINT   = 3'd3;
	localparam logic [OP_W-1:0] OP_HEADER = 3'd4;
	localparam logic [OP_W-1:0] OP_OID    = 3'd5;

	typedef struct packed {
		logic [MAX_OCTETS-1:0][OCTET_W-1:0] octets;
		logic [CNT_W-1:0]                   count;
	} frame_t;

endpackage

// ===== rtl/ber_enc_if.sv =====
// ----------------------------------------------------------------------------
// BER encoder channels
// Valid/ready channels for input items and for encoded octets.
// ----------------------------------------------------------------------------
interface ber_enc_item_if
	import ber_enc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [TAG_W-1:0]   tag;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output op, output tag, output value, input ready);
	modport sink (input valid, input op, input tag, input value, output ready);
endinterface

interface ber_enc_octet_if
	import ber_enc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OCTET_W-1:0] out_byte;
	logic               last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/ber_enc_format.sv =====
// ----------------------------------------------------------------------------
// BER encoder formatter
// Builds the complete octet sequence of one registered item in one pass.
// ----------------------------------------------------------------------------
module ber_enc_format
	import ber_enc_pkg::*;
(
	input  logic [OP_W-1:0]    op,
	input  logic [TAG_W-1:0]   tag,
	input  logic [VALUE_W-1:0] value,
	output frame_t             frame
);

	localparam logic [VALUE_W-1:0] VALUE_MASK =
		VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);
	localparam int SIGN_BIT = VALUE_BITS - 1;
	localparam int SEQ_W    = MAX_OCTETS * OCTET_W;

	// Left-aligns the low n octets of a five-octet word.
	function automatic logic [39:0] align_be(input logic [39:0] w, input logic [CNT_W-1:0] n);
		logic [39:0] r;
		begin
			case (n)
				3'd1:    r = w << 32;
				3'd2:    r = w << 24;
				3'd3:    r = w << 16;
				3'd4:    r = w << 8;
				default: r = w;
			endcase
			return r;
		end
	endfunction

	logic [VALUE_W-1:0] v;
	logic [VALUE_W-1:0] sv;
	logic [CNT_W-1:0]   sn;
	logic [CNT_W-1:0]   sig;
	logic [CNT_W-1:0]   un;
	logic               top_set;
	logic [34:0]        vx;
	logic [4:0][6:0]    grp;
	logic [CNT_W-1:0]   on;
	logic [CNT_W-1:0]   gi;
	logic [39:0]        oid_seq;
	logic [SEQ_W-1:0]   seq;
	logic [CNT_W-1:0]   cnt;

	always_comb begin
		v  = value & VALUE_MASK;
		sv = v[SIGN_BIT] ? (v | ~VALUE_MASK) : v;

		if (sv[31:7] == '0 || &sv[31:7]) begin
			sn = 3'd1;
		end else if (sv[31:15] == '0 || &sv[31:15]) begin
			sn = 3'd2;
		end else if (sv[31:23] == '0 || &sv[31:23]) begin
			sn = 3'd3;
		end else begin
			sn = 3'd4;
		end

		if (v[31:8] == '0) begin
			sig = 3'd1;
			top_set = v[7];
		end else if (v[31:16] == '0) begin
			sig = 3'd2;
			top_set = v[15];
		end else if (v[31:24] == '0) begin
			sig = 3'd3;
			top_set = v[23];
		end else begin
			sig = 3'd4;
			top_set = v[31];
		end
		un = sig + CNT_W'(top_set);

		vx = {3'b000, v};
		for (int i = 0; i < 5; i++) begin
			grp[i] = vx[7*i +: 7];
		end
		if (grp[4] != '0) begin
			on = 3'd5;
		end else if (grp[3] != '0) begin
			on = 3'd4;
		end else if (grp[2] != '0) begin
			on = 3'd3;
		end else if (grp[1] != '0) begin
			on = 3'd2;
		end else begin
			on = 3'd1;
		end
		oid_seq = '0;
		for (int k = 0; k < 5; k++) begin
			gi = on - 3'd1 - CNT_W'(k);
			if (CNT_W'(k) < on) begin
				oid_seq[39-8*k -: 8] = {(CNT_W'(k) < on - 3'd1), grp[gi]};
			end
		end

		case (op)
			OP_NULL: begin
				seq = {tag, 8'h00, 40'h0};
				cnt = 3'd2;
			end
			OP_BOOL: begin
				seq = {tag, 8'h01, ((v != '0) ? 8'hff : 8'h00), 32'h0};
				cnt = 3'd3;
			end
			OP_SINT: begin
				seq = {tag, 5'b0, sn, align_be({8'h00, sv}, sn)};
				cnt = 3'd2 + sn;
			end
			OP_UINT: begin
				seq = {tag, 5'b0, un, align_be({8'h00, v}, un)};
				cnt = 3'd2 + un;
			end
			OP_HEADER: begin
				if (v <= 32'd127) begin
					seq = {tag, v[7:0], 40'h0};
					cnt = 3'd2;
				end else begin
					seq = {tag, 5'b10000, sig, align_be({8'h00, v}, sig)};
					cnt = 3'd2 + sig;
				end
			end
			OP_OID: begin
				seq = {oid_seq, 16'h0};
				cnt = on;
			end
			default: begin
				seq = '0;
				cnt = '0;
			end
		endcase

		for (int k = 0; k < MAX_OCTETS; k++) begin
			frame.octets[k] = seq[SEQ_W-1-8*k -: 8];
		end
		frame.count = cnt;
	end

endmodule

// ===== rtl/ber_enc_serializer.sv =====
// ----------------------------------------------------------------------------
// BER encoder serializer
// Holds one formatted frame and sends one octet per cycle while octet.ready.
// ----------------------------------------------------------------------------
module ber_enc_serializer
	import ber_enc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  frame_t            frame,
	input  logic              frame_valid,
	output logic              frame_take,
	ber_enc_octet_if.source   octet
);

	frame_t           frame_q;
	logic [CNT_W-1:0] idx_q;
	logic             busy_q;
	logic             at_last;

	assign at_last    = (idx_q == frame_q.count - 3'd1);
	assign frame_take = !busy_q || (octet.ready && at_last);

	assign octet.valid    = busy_q;
	assign octet.out_byte = frame_q.octets[idx_q];
	assign octet.last     = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (frame_take) begin
			busy_q <= frame_valid && (frame.count != '0);
			idx_q  <= '0;
		end else if (octet.ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			frame_q <= frame;
		end
	end

endmodule

// ===== rtl/ber_primitive_tlv_encoder.sv =====
// ----------------------------------------------------------------------------
// BER primitive TLV encoder
// Encodes null, boolean, integer, header and OID subidentifier items as BER.
// ----------------------------------------------------------------------------
// Each accepted item is registered, formatted in one pass and then sent as one
// octet per cycle while the output is ready, with last marking its final
// octet. Each item has 1 to 7 octets (none for the unused operation codes),
// and the octet serializer sets the sustained rate. An item passes through
// the input register and then the serializer's frame register before its
// first octet is offered, and the next item is taken while the current one
// is still being sent.
module ber_primitive_tlv_encoder
	import ber_enc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	ber_enc_item_if.sink    item,
	ber_enc_octet_if.source octet
);

	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [VALUE_W-1:0] value_s1;
	frame_t             frame;
	logic               frame_take;

	assign item.ready = !valid_s1 || frame_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (frame_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1    <= item.op;
			tag_s1   <= item.tag;
			value_s1 <= item.value;
		end
	end

	ber_enc_format u_format (
		.op    (op_s1),
		.tag   (tag_s1),
		.value (value_s1),
		.frame (frame)
	);

	ber_enc_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.frame_valid (valid_s1),
		.frame_take  (frame_take),
		.octet       (octet)
	);

endmodule

// ===== rtl/ber_enc_checker.sv =====
// ----------------------------------------------------------------------------
// BER encoder checker
// Port-level assertions on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ber_enc_checker
	import ber_enc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               octet_valid,
	input logic               octet_ready,
	input logic [OCTET_W-1:0] octet_byte,
	input logic               octet_last
);

	a_octet_hold: assert property (@(posedge clk) disable iff (!arst_n)
		octet_valid && !octet_ready |=> octet_valid && $stable(octet_byte)
			&& $stable(octet_last))
		else $error("Stalled octet word changed or was withdrawn.");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!octet_valid |-> item_ready)
		else $error("Input not ready while the output side is idle.");

	a_start_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(octet_valid) |-> $past(item_valid && item_ready, 2))
		else $error("Octet output started without an item accepted two cycles before.");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		octet_valid && octet_ready && octet_last |-> item_ready)
		else $error("Input not ready when the final octet of an item is taken.");

endmodule

bind ber_primitive_tlv_encoder ber_enc_checker u_ber_enc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.octet_valid (octet.valid),
	.octet_ready (octet.ready),
	.octet_byte  (octet.out_byte),
	.octet_last  (octet.last)
);
